[rtl/core/lr_config_grammar_parser_assert.svh]
// assertion macros for the configuration grammar parser
// expects aclk and aresetn in the scope where a macro is used
`ifndef LR_CONFIG_GRAMMAR_PARSER_ASSERT_SVH
`define LR_CONFIG_GRAMMAR_PARSER_ASSERT_SVH

// condition and consequence in the same cycle
`define LCGP_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("lcgp: same-cycle check failed");

// consequence in the cycle after the condition
`define LCGP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("lcgp: next-cycle check failed");

`endif

[rtl/core/lcgp_pkg.sv]
// types, constants and parse tables for the configuration grammar parser
// no dependencies
`timescale 1ns / 1ps

package lcgp_pkg;

    localparam int STACK_DEPTH  = 64;
    localparam int HANDLE_WIDTH = 16;
    localparam int MAX_REDUCE   = 8;

    localparam int KIND_W   = 3;
    localparam int EVENT_W  = 3;
    localparam int FIELD_W  = 16;
    localparam int STATE_W  = 4;
    localparam int IDX_W    = $clog2(STACK_DEPTH);
    localparam int CNT_W    = $clog2(STACK_DEPTH + 1);
    localparam int ITER_W   = $clog2(MAX_REDUCE + 1);

    localparam logic [FIELD_W-1:0] HANDLE_MASK =
        FIELD_W'((64'd1 << HANDLE_WIDTH) - 64'd1);

    typedef enum logic [KIND_W-1:0] {
        KIND_END    = 3'd0,
        KIND_IDENT  = 3'd1,
        KIND_EQUALS = 3'd2,
        KIND_LBRACE = 3'd3,
        KIND_RBRACE = 3'd4,
        KIND_INT    = 3'd5,
        KIND_STR    = 3'd6,
        KIND_SEMI   = 3'd7
    } kind_t;

    typedef enum logic [EVENT_W-1:0] {
        EV_ADD      = 3'd0,
        EV_ENTER    = 3'd1,
        EV_LEAVE    = 3'd2,
        EV_ACCEPT   = 3'd3,
        EV_SYNTAX   = 3'd4,
        EV_OVERFLOW = 3'd5
    } event_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_EVAL = 2'd1,
        ST_GOTO = 2'd2
    } ctrl_state_t;

    typedef enum logic [1:0] {
        STEP_SHIFT  = 2'd0,
        STEP_REDUCE = 2'd1,
        STEP_ACCEPT = 2'd2,
        STEP_SYNTAX = 2'd3
    } step_t;

    typedef struct packed {
        logic [KIND_W-1:0]  token_kind;
        logic [FIELD_W-1:0] token_handle;
    } token_t;

    typedef struct packed {
        logic [EVENT_W-1:0] event_res;
        logic [FIELD_W-1:0] key_handle;
        logic [FIELD_W-1:0] value_handle;
    } result_t;

    typedef struct packed {
        logic        hit;
        logic [STATE_W-1:0] st;
    } lookup_t;

    typedef struct packed {
        logic       hit;
        logic [2:0] rule;
    } rule_hit_t;

    // controller to datapath
    typedef struct packed {
        logic   load;
        logic   shift;
        logic   reduce;
        logic   push_goto;
        logic   restart;
        logic   ev_valid;
        event_t ev_code;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        step_t  step;
        logic   full;
        logic   shift_emit;
        event_t shift_ev;
        logic   goto_hit;
        logic   out_free;
    } dp_status_t;

    function automatic lookup_t shift_lookup(logic [STATE_W-1:0] st, kind_t kind);
        lookup_t r;
        r = '{hit: 1'b0, st: '0};
        case (st)
            4'd1: if (kind == KIND_IDENT)  r = '{hit: 1'b1, st: 4'd2};
            4'd2: begin
                if (kind == KIND_EQUALS) r = '{hit: 1'b1, st: 4'd4};
                if (kind == KIND_LBRACE) r = '{hit: 1'b1, st: 4'd5};
            end
            4'd4: begin
                if (kind == KIND_INT) r = '{hit: 1'b1, st: 4'd7};
                if (kind == KIND_STR) r = '{hit: 1'b1, st: 4'd8};
            end
            4'd6: if (kind == KIND_SEMI) r = '{hit: 1'b1, st: 4'd10};
            4'd9: begin
                if (kind == KIND_IDENT)  r = '{hit: 1'b1, st: 4'd2};
                if (kind == KIND_RBRACE) r = '{hit: 1'b1, st: 4'd11};
            end
            default: r = '{hit: 1'b0, st: '0};
        endcase
        return r;
    endfunction

    function automatic rule_hit_t reduce_lookup(logic [STATE_W-1:0] st, kind_t kind);
        rule_hit_t r;
        r = '{hit: 1'b0, rule: '0};
        case (st)
            4'd0: if (kind inside {KIND_END, KIND_IDENT})
                r = '{hit: 1'b1, rule: 3'd2};
            4'd3: if (kind inside {KIND_END, KIND_IDENT, KIND_RBRACE})
                r = '{hit: 1'b1, rule: 3'd1};
            4'd5: if (kind inside {KIND_IDENT, KIND_RBRACE})
                r = '{hit: 1'b1, rule: 3'd2};
            4'd7: if (kind == KIND_SEMI) r = '{hit: 1'b1, rule: 3'd5};
            4'd8: if (kind == KIND_SEMI) r = '{hit: 1'b1, rule: 3'd6};
            4'd10: if (kind inside {KIND_END, KIND_IDENT, KIND_RBRACE})
                r = '{hit: 1'b1, rule: 3'd3};
            4'd11: if (kind inside {KIND_END, KIND_IDENT, KIND_RBRACE})
                r = '{hit: 1'b1, rule: 3'd4};
            default: r = '{hit: 1'b0, rule: '0};
        endcase
        return r;
    endfunction

    // entries popped per rule
    function automatic logic [1:0] rule_pop(logic [2:0] rule);
        logic [1:0] p;
        case (rule)
            3'd0, 3'd5, 3'd6:       p = 2'd1;
            3'd1, 3'd3, 3'd4:       p = 2'd3;
            default:                p = 2'd0;
        endcase
        return p;
    endfunction

    // left side: 0 S, 1 STMTS, 2 STMT, 3 VALUE
    function automatic logic [1:0] rule_lhs(logic [2:0] rule);
        logic [1:0] l;
        case (rule)
            3'd1, 3'd2:       l = 2'd1;
            3'd3, 3'd4:       l = 2'd2;
            3'd5, 3'd6:       l = 2'd3;
            default:          l = 2'd0;
        endcase
        return l;
    endfunction

    function automatic lookup_t goto_lookup(logic [STATE_W-1:0] st, logic [1:0] lhs);
        lookup_t r;
        r = '{hit: 1'b0, st: '0};
        case ({st, lhs})
            {4'd0, 2'd1}: r = '{hit: 1'b1, st: 4'd1};
            {4'd2, 2'd2}: r = '{hit: 1'b1, st: 4'd3};
            {4'd4, 2'd3}: r = '{hit: 1'b1, st: 4'd6};
            {4'd5, 2'd1}: r = '{hit: 1'b1, st: 4'd9};
            default:      r = '{hit: 1'b0, st: '0};
        endcase
        return r;
    endfunction

endpackage

[rtl/core/lr_config_grammar_parser.sv]
// lr shift-reduce parser for a small configuration grammar, top level
// Usage: one token per input item on s_* (token_kind, token_handle), zero or
// one event per token on m_* (event_res, key_handle, value_handle).
// A token is taken only while the block is idle; it then runs its reductions,
// one pass per reduction, and finishes with a shift, accept or error.
// Steps: a token that shifts at once is loaded, evaluated in the evaluate state and
// has its event registered on m_valid; each reduction before the shift adds a pass to pop
// and read the stack memory and a goto pass to look up the goto and push.
// A new token is taken only after the last one is through; R, the number of reductions
// that a token causes, is 0 to 2 for this grammar.
// Reset: the stack holds only the bottom state zero, count one, last key zero;
// no clearing pass is needed since the bottom entry is implied, not stored.
// Accept, syntax error and stack overflow all return to that same state.
// Stall: the event sits in an output register until m_ready; a next event that
// is due while it still waits holds the parse where it is until the slot frees.
`timescale 1ns / 1ps

`include "lr_config_grammar_parser_assert.svh"

module lr_config_grammar_parser (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  lcgp_pkg::token_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output lcgp_pkg::result_t m_data
);

    // command and status between controller and datapath
    lcgp_pkg::dp_cmd_t    cmd;
    lcgp_pkg::dp_status_t sts;

    // state machine: idle, evaluate top of stack, goto after a pop
    lcgp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // stack memory, parse registers and result register
    lcgp_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .sts     (sts),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .m_data  (m_data)
    );

    // every return to the initial state reports an event
    `LCGP_ASSERT_NOW(a_restart_reports, cmd.restart, cmd.ev_valid)
    // never push onto a full stack
    `LCGP_ASSERT_NOW(a_no_push_when_full, cmd.shift || cmd.push_goto, !sts.full)
    // one item in flight at a time
    `LCGP_ASSERT_NEXT(a_one_item, s_valid && s_ready, !s_ready)
    // an issued event shows up on the output
    `LCGP_ASSERT_NEXT(a_event_shown, cmd.ev_valid, m_valid)

endmodule

[rtl/core/lcgp_datapath.sv]
// parser datapath: token hold, stack memory, top and count, last key, result register
// depends on lcgp_pkg
`timescale 1ns / 1ps

module lcgp_datapath (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  lcgp_pkg::token_t     s_data,
    input  lcgp_pkg::dp_cmd_t    cmd,
    output lcgp_pkg::dp_status_t sts,
    input  logic                 m_ready,
    output logic                 m_valid,
    output lcgp_pkg::result_t    m_data
);

    logic [lcgp_pkg::STATE_W-1:0] stack_mem [lcgp_pkg::STACK_DEPTH];

    lcgp_pkg::kind_t               kind_reg;
    logic [lcgp_pkg::FIELD_W-1:0]  handle_reg;
    logic [lcgp_pkg::STATE_W-1:0]  top_reg;
    logic [lcgp_pkg::CNT_W-1:0]    count_reg;
    logic [lcgp_pkg::FIELD_W-1:0]  last_key_reg;
    logic [lcgp_pkg::ITER_W-1:0]   iter_reg;
    logic [1:0]                    lhs_reg;
    logic [lcgp_pkg::STATE_W-1:0]  rd_reg;
    logic                          rd_zero_reg;
    logic                          m_valid_reg;
    lcgp_pkg::result_t             m_data_reg;

    lcgp_pkg::lookup_t             sh;
    lcgp_pkg::rule_hit_t           rd;
    lcgp_pkg::lookup_t             gt;
    logic [1:0]                    pops;
    logic [lcgp_pkg::CNT_W-1:0]    count_pop;
    logic [lcgp_pkg::IDX_W-1:0]    rd_addr;
    logic [lcgp_pkg::STATE_W-1:0]  goto_from;
    logic [lcgp_pkg::STATE_W-1:0]  push_st;
    logic                          push_en;

    always_comb begin
        sh        = lcgp_pkg::shift_lookup(top_reg, kind_reg);
        rd        = lcgp_pkg::reduce_lookup(top_reg, kind_reg);
        pops      = lcgp_pkg::rule_pop(rd.rule);
        count_pop = count_reg - lcgp_pkg::CNT_W'(pops);
        rd_addr   = lcgp_pkg::IDX_W'(count_pop - lcgp_pkg::CNT_W'(1));
        goto_from = rd_zero_reg ? '0 : rd_reg;
        gt        = lcgp_pkg::goto_lookup(goto_from, lhs_reg);
    end

    assign push_en = cmd.shift || cmd.push_goto;
    assign push_st = cmd.shift ? sh.st : gt.st;

    // one decision per loop pass
    always_comb begin
        sts.full     = (count_reg == lcgp_pkg::CNT_W'(lcgp_pkg::STACK_DEPTH));
        sts.goto_hit = gt.hit;
        sts.out_free = !m_valid_reg || m_ready;
        if (iter_reg == lcgp_pkg::ITER_W'(lcgp_pkg::MAX_REDUCE)) begin
            sts.step = lcgp_pkg::STEP_SYNTAX;
        end else if (sh.hit) begin
            sts.step = lcgp_pkg::STEP_SHIFT;
        end else if (rd.hit) begin
            sts.step = (count_reg <= lcgp_pkg::CNT_W'(pops)) ? lcgp_pkg::STEP_SYNTAX
                                                             : lcgp_pkg::STEP_REDUCE;
        end else if (top_reg == lcgp_pkg::STATE_W'(1) && kind_reg == lcgp_pkg::KIND_END) begin
            sts.step = lcgp_pkg::STEP_ACCEPT;
        end else begin
            sts.step = lcgp_pkg::STEP_SYNTAX;
        end
        case (kind_reg) inside
            lcgp_pkg::KIND_LBRACE: begin
                sts.shift_emit = 1'b1;
                sts.shift_ev   = lcgp_pkg::EV_ENTER;
            end
            lcgp_pkg::KIND_RBRACE: begin
                sts.shift_emit = 1'b1;
                sts.shift_ev   = lcgp_pkg::EV_LEAVE;
            end
            lcgp_pkg::KIND_INT, lcgp_pkg::KIND_STR: begin
                sts.shift_emit = 1'b1;
                sts.shift_ev   = lcgp_pkg::EV_ADD;
            end
            default: begin
                sts.shift_emit = 1'b0;
                sts.shift_ev   = lcgp_pkg::EV_ADD;
            end
        endcase
    end

    // stack memory: bottom entry is never written and reads as state zero
    always_ff @(posedge aclk) begin
        if (push_en) begin
            stack_mem[count_reg[lcgp_pkg::IDX_W-1:0]] <= push_st;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.reduce) begin
            rd_reg      <= stack_mem[rd_addr];
            rd_zero_reg <= (rd_addr == '0);
            lhs_reg     <= lcgp_pkg::rule_lhs(rd.rule);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            kind_reg   <= lcgp_pkg::kind_t'(s_data.token_kind);
            handle_reg <= s_data.token_handle & lcgp_pkg::HANDLE_MASK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            top_reg      <= '0;
            count_reg    <= lcgp_pkg::CNT_W'(1);
            last_key_reg <= '0;
            iter_reg     <= '0;
        end else begin
            if (cmd.load) begin
                iter_reg <= '0;
            end
            if (cmd.restart) begin
                top_reg      <= '0;
                count_reg    <= lcgp_pkg::CNT_W'(1);
                last_key_reg <= '0;
            end else if (push_en) begin
                top_reg   <= push_st;
                count_reg <= count_reg + lcgp_pkg::CNT_W'(1);
                if (cmd.shift && kind_reg == lcgp_pkg::KIND_IDENT) begin
                    last_key_reg <= handle_reg;
                end
                if (cmd.push_goto) begin
                    iter_reg <= iter_reg + lcgp_pkg::ITER_W'(1);
                end
            end else if (cmd.reduce) begin
                count_reg <= count_pop;
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.ev_valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.ev_valid) begin
            m_data_reg.event_res <= cmd.ev_code;
            m_data_reg.key_handle <=
                (cmd.ev_code == lcgp_pkg::EV_ADD || cmd.ev_code == lcgp_pkg::EV_ENTER)
                ? last_key_reg : '0;
            m_data_reg.value_handle <= (cmd.ev_code == lcgp_pkg::EV_ADD) ? handle_reg : '0;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

[rtl/core/lcgp_ctrl.sv]
// parser controller: accepts a token, steps the reduce loop, issues events
// depends on lcgp_pkg
`timescale 1ns / 1ps

module lcgp_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  lcgp_pkg::dp_status_t sts,
    output lcgp_pkg::dp_cmd_t    cmd
);

    lcgp_pkg::ctrl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lcgp_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            lcgp_pkg::ST_IDLE: begin
                if (s_valid) state_next = lcgp_pkg::ST_EVAL;
            end
            lcgp_pkg::ST_EVAL: begin
                case (sts.step)
                    lcgp_pkg::STEP_SHIFT: begin
                        if (sts.out_free || (!sts.full && !sts.shift_emit))
                            state_next = lcgp_pkg::ST_IDLE;
                    end
                    lcgp_pkg::STEP_REDUCE: state_next = lcgp_pkg::ST_GOTO;
                    default: begin
                        if (sts.out_free) state_next = lcgp_pkg::ST_IDLE;
                    end
                endcase
            end
            lcgp_pkg::ST_GOTO: begin
                if (sts.goto_hit && !sts.full) begin
                    state_next = lcgp_pkg::ST_EVAL;
                end else if (sts.out_free) begin
                    state_next = lcgp_pkg::ST_IDLE;
                end
            end
            default: state_next = lcgp_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd         = '0;
        cmd.ev_code = lcgp_pkg::EV_ADD;
        s_ready     = (state_reg == lcgp_pkg::ST_IDLE);
        case (state_reg)
            lcgp_pkg::ST_IDLE: begin
                cmd.load = s_valid;
            end
            lcgp_pkg::ST_EVAL: begin
                case (sts.step)
                    lcgp_pkg::STEP_SHIFT: begin
                        if (sts.full) begin
                            if (sts.out_free) begin
                                cmd.restart  = 1'b1;
                                cmd.ev_valid = 1'b1;
                                cmd.ev_code  = lcgp_pkg::EV_OVERFLOW;
                            end
                        end else if (!sts.shift_emit) begin
                            cmd.shift = 1'b1;
                        end else if (sts.out_free) begin
                            cmd.shift    = 1'b1;
                            cmd.ev_valid = 1'b1;
                            cmd.ev_code  = sts.shift_ev;
                        end
                    end
                    lcgp_pkg::STEP_REDUCE: begin
                        cmd.reduce = 1'b1;
                    end
                    lcgp_pkg::STEP_ACCEPT: begin
                        if (sts.out_free) begin
                            cmd.restart  = 1'b1;
                            cmd.ev_valid = 1'b1;
                            cmd.ev_code  = lcgp_pkg::EV_ACCEPT;
                        end
                    end
                    default: begin
                        if (sts.out_free) begin
                            cmd.restart  = 1'b1;
                            cmd.ev_valid = 1'b1;
                            cmd.ev_code  = lcgp_pkg::EV_SYNTAX;
                        end
                    end
                endcase
            end
            lcgp_pkg::ST_GOTO: begin
                if (sts.goto_hit && !sts.full) begin
                    cmd.push_goto = 1'b1;
                end else if (sts.out_free) begin
                    cmd.restart  = 1'b1;
                    cmd.ev_valid = 1'b1;
                    cmd.ev_code  = sts.goto_hit ? lcgp_pkg::EV_OVERFLOW : lcgp_pkg::EV_SYNTAX;
                end
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

[dv/lr_config_grammar_parser_test.sv]
// self-checking testbench for lr_config_grammar_parser: token items in, parse events out
// depends on lcgp_pkg for the token, event and kind types
`timescale 1ns / 1ps

module lr_config_grammar_parser_test;
    import lcgp_pkg::*;

    // nonterminal codes for the goto lookup
    localparam logic [1:0] NT_STMTS = 2'd1;
    localparam logic [1:0] NT_STMT  = 2'd2;
    localparam logic [1:0] NT_VALUE = 2'd3;

    // least number of tokens per random phase
    localparam int PHASE_ITEMS = 433;

    // shadow parser: tracks the parse stack and queues the events it should emit
    class parse_scoreboard;
        logic [STATE_W-1:0] state_stack [STACK_DEPTH];
        int unsigned        depth;
        logic [15:0]        last_key;
        result_t            expected_events [$];
        int                 errors;

        function new();
            errors = 0;
            restart();
        endfunction

        function void restart();
            foreach (state_stack[i]) state_stack[i] = '0;
            depth    = 1;
            last_key = '0;
        endfunction

        // {hit, next state}
        function logic [4:0] shift_target(logic [3:0] st, kind_t k);
            case ({st, k})
                {4'd1, KIND_IDENT}, {4'd9, KIND_IDENT}: return {1'b1, 4'd2};
                {4'd2, KIND_EQUALS}:                    return {1'b1, 4'd4};
                {4'd2, KIND_LBRACE}:                    return {1'b1, 4'd5};
                {4'd4, KIND_INT}:                       return {1'b1, 4'd7};
                {4'd4, KIND_STR}:                       return {1'b1, 4'd8};
                {4'd6, KIND_SEMI}:                      return {1'b1, 4'd10};
                {4'd9, KIND_RBRACE}:                    return {1'b1, 4'd11};
                default:                                return 5'd0;
            endcase
        endfunction

        // {hit, entries to pop, left side}
        function logic [4:0] reduce_rule(logic [3:0] st, kind_t k);
            logic follow_stmt;
            follow_stmt = (k == KIND_END) || (k == KIND_IDENT) || (k == KIND_RBRACE);
            case (st)
                4'd0:  if (k == KIND_END || k == KIND_IDENT) return {1'b1, 2'd0, NT_STMTS};
                4'd3:  if (follow_stmt) return {1'b1, 2'd3, NT_STMTS};
                4'd5:  if (k == KIND_IDENT || k == KIND_RBRACE) return {1'b1, 2'd0, NT_STMTS};
                4'd7,
                4'd8:  if (k == KIND_SEMI) return {1'b1, 2'd1, NT_VALUE};
                4'd10,
                4'd11: if (follow_stmt) return {1'b1, 2'd3, NT_STMT};
                default: ;
            endcase
            return 5'd0;
        endfunction

        // {hit, next state}
        function logic [4:0] goto_target(logic [3:0] st, logic [1:0] lhs);
            case ({st, lhs})
                {4'd0, NT_STMTS}: return {1'b1, 4'd1};
                {4'd2, NT_STMT}:  return {1'b1, 4'd3};
                {4'd4, NT_VALUE}: return {1'b1, 4'd6};
                {4'd5, NT_STMTS}: return {1'b1, 4'd9};
                default:          return 5'd0;
            endcase
        endfunction

        function void post(event_t e, logic [15:0] key, logic [15:0] val);
            result_t r;
            r.event_res    = e;
            r.key_handle   = key;
            r.value_handle = val;
            expected_events.push_back(r);
        endfunction

        // terminal events drop the parse back to its reset state
        function void end_parse(event_t e);
            post(e, '0, '0);
            restart();
        endfunction

        // run reductions, then shift, accept or reject one token
        function void note_token(token_t t);
            kind_t       k;
            logic [15:0] h;
            logic [3:0]  top;
            logic [4:0]  sh;
            logic [4:0]  rd;
            logic [4:0]  gt;
            bit          settled;
            k       = kind_t'(t.token_kind);
            h       = t.token_handle & HANDLE_MASK;
            settled = 1'b0;
            for (int n = 0; n < MAX_REDUCE && !settled; n++) begin
                top = state_stack[depth-1];
                sh  = shift_target(top, k);
                rd  = reduce_rule(top, k);
                if (sh[4]) begin
                    settled = 1'b1;
                    if (depth >= STACK_DEPTH) begin
                        end_parse(EV_OVERFLOW);
                    end else begin
                        state_stack[depth] = sh[3:0];
                        depth++;
                        case (k)
                            KIND_IDENT:         last_key = h;
                            KIND_LBRACE:        post(EV_ENTER, last_key, '0);
                            KIND_RBRACE:        post(EV_LEAVE, '0, '0);
                            KIND_INT, KIND_STR: post(EV_ADD, last_key, h);
                            default: ;
                        endcase
                    end
                end else if (rd[4]) begin
                    if (depth <= rd[3:2]) begin
                        settled = 1'b1;
                        end_parse(EV_SYNTAX);
                    end else begin
                        depth -= rd[3:2];
                        gt = goto_target(state_stack[depth-1], rd[1:0]);
                        if (!gt[4]) begin
                            settled = 1'b1;
                            end_parse(EV_SYNTAX);
                        end else if (depth >= STACK_DEPTH) begin
                            settled = 1'b1;
                            end_parse(EV_OVERFLOW);
                        end else begin
                            state_stack[depth] = gt[3:0];
                            depth++;
                        end
                    end
                end else begin
                    settled = 1'b1;
                    if (top == 4'd1 && k == KIND_END) begin
                        end_parse(EV_ACCEPT);
                    end else begin
                        end_parse(EV_SYNTAX);
                    end
                end
            end
            // reduction cascade too long
            if (!settled) end_parse(EV_SYNTAX);
        endfunction

        function void check_event(result_t got);
            result_t want;
            if (expected_events.size() == 0) begin
                $error("unexpected event: event_res %0d key_handle %0h value_handle %0h",
                       got.event_res, got.key_handle, got.value_handle);
                errors++;
                return;
            end
            want = expected_events.pop_front();
            if (got.event_res !== want.event_res) begin
                $error("event_res: expected %0d, got %0d", want.event_res, got.event_res);
                errors++;
            end
            if (got.key_handle !== want.key_handle) begin
                $error("key_handle: expected %0h, got %0h", want.key_handle, got.key_handle);
                errors++;
            end
            if (got.value_handle !== want.value_handle) begin
                $error("value_handle: expected %0h, got %0h",
                       want.value_handle, got.value_handle);
                errors++;
            end
        endfunction
    endclass

    logic    aclk = 1'b0;
    logic    aresetn;
    logic    s_valid;
    logic    s_ready;
    token_t  s_data;
    logic    m_valid;
    logic    m_ready;
    result_t m_data;

    // idle chances in percent, changed per phase
    int src_idle_pct;
    int sink_idle_pct;

    parse_scoreboard sb = new();

    // tokens waiting to be sent
    token_t token_run [$];

    lr_config_grammar_parser dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // 4 ns clock
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // result side: check every accepted event, then pick the next ready
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_event(m_data);
        end
        m_ready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // hard stop if the block hangs
    initial begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic token_t tok(kind_t k, logic [15:0] h);
        token_t t;
        t.token_kind   = k;
        t.token_handle = h;
        return t;
    endfunction

    function automatic logic [15:0] rand_handle();
        return 16'($urandom);
    endfunction

    function automatic kind_t rand_kind();
        return kind_t'($urandom_range(7));
    endfunction

    // key = value;
    task automatic add_assignment();
        token_run.push_back(tok(KIND_IDENT, rand_handle()));
        token_run.push_back(tok(KIND_EQUALS, rand_handle()));
        token_run.push_back(tok($urandom_range(1) ? KIND_INT : KIND_STR, rand_handle()));
        token_run.push_back(tok(KIND_SEMI, rand_handle()));
    endtask

    // deep nesting; past 19 levels the stack overflows
    task automatic add_tower(int levels);
        repeat (levels) begin
            token_run.push_back(tok(KIND_IDENT, rand_handle()));
            token_run.push_back(tok(KIND_LBRACE, rand_handle()));
        end
        add_assignment();
        repeat (levels) token_run.push_back(tok(KIND_RBRACE, rand_handle()));
        token_run.push_back(tok(KIND_END, rand_handle()));
    endtask

    // mostly well-formed documents with random content, some noise or damage
    task automatic add_document();
        int pick;
        int nest;
        int nest_cap;
        int pos;
        pick = $urandom_range(99);
        if (pick < 4) begin
            add_tower($urandom_range(18, 24));
        end else if (pick < 12) begin
            repeat ($urandom_range(1, 6)) token_run.push_back(tok(rand_kind(), rand_handle()));
        end else begin
            nest     = 0;
            nest_cap = $urandom_range(0, 4);
            repeat ($urandom_range(1, 8)) begin
                pick = $urandom_range(99);
                if (nest > 0 && pick < 25) begin
                    token_run.push_back(tok(KIND_RBRACE, rand_handle()));
                    nest--;
                end else if (nest < nest_cap && pick < 50) begin
                    token_run.push_back(tok(KIND_IDENT, rand_handle()));
                    token_run.push_back(tok(KIND_LBRACE, rand_handle()));
                    nest++;
                end else begin
                    add_assignment();
                end
            end
            repeat (nest) token_run.push_back(tok(KIND_RBRACE, rand_handle()));
            token_run.push_back(tok(KIND_END, rand_handle()));
            // damage: a changed kind, a dropped or an extra token
            pick = $urandom_range(99);
            pos  = $urandom_range(token_run.size() - 1);
            if (pick < 10) begin
                token_run[pos].token_kind = rand_kind();
            end else if (pick < 16) begin
                token_run.delete(pos);
            end else if (pick < 22) begin
                token_run.insert(pos, tok(rand_kind(), rand_handle()));
            end
        end
    endtask

    // one item on the input channel, with random gaps before it
    task automatic drive_token(token_t t);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= t;
        do @(posedge aclk); while (!s_ready);
        sb.note_token(t);
    endtask

    task automatic send_run();
        while (token_run.size() != 0) drive_token(token_run.pop_front());
    endtask

    // hold the input until every queued event has come out
    task automatic drain();
        s_valid <= 1'b0;
        while (sb.expected_events.size() != 0) @(posedge aclk);
    endtask

    initial begin
        int sent;
        s_valid       <= 1'b0;
        s_data        <= '0;
        m_ready       <= 1'b0;
        aresetn       <= 1'b0;
        src_idle_pct  = 22;
        sink_idle_pct = 47;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty document, stray tokens, handle extremes, sections
        token_run.push_back(tok(KIND_END, 16'h0000));
        token_run.push_back(tok(KIND_EQUALS, 16'hffff));
        token_run.push_back(tok(KIND_IDENT, 16'hffff));
        token_run.push_back(tok(KIND_EQUALS, 16'h0000));
        token_run.push_back(tok(KIND_INT, 16'h0000));
        token_run.push_back(tok(KIND_SEMI, 16'hffff));
        token_run.push_back(tok(KIND_IDENT, 16'h0000));
        token_run.push_back(tok(KIND_EQUALS, 16'hffff));
        token_run.push_back(tok(KIND_STR, 16'hffff));
        token_run.push_back(tok(KIND_SEMI, 16'h0000));
        token_run.push_back(tok(KIND_IDENT, 16'h8001));
        token_run.push_back(tok(KIND_LBRACE, 16'h5a5a));
        token_run.push_back(tok(KIND_RBRACE, 16'ha5a5));
        token_run.push_back(tok(KIND_END, 16'hffff));
        // no action at the start for each remaining kind
        token_run.push_back(tok(KIND_RBRACE, 16'h0001));
        token_run.push_back(tok(KIND_SEMI, 16'h0002));
        token_run.push_back(tok(KIND_LBRACE, 16'h0004));
        token_run.push_back(tok(KIND_INT, 16'h0008));
        token_run.push_back(tok(KIND_STR, 16'h0010));
        // end right after a key
        token_run.push_back(tok(KIND_IDENT, 16'h7fff));
        token_run.push_back(tok(KIND_END, 16'h8000));
        send_run();
        drain();

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    src_idle_pct  = 22;
                    sink_idle_pct = 47;
                end
                1: begin
                    src_idle_pct  = 47;
                    sink_idle_pct = 22;
                end
                default: begin
                    src_idle_pct  = 0;
                    sink_idle_pct = 0;
                end
            endcase
            sent = 0;
            // make sure the overflow path is hit early
            if (phase == 0) add_tower(24);
            while (sent < PHASE_ITEMS) begin
                add_document();
                sent += token_run.size();
                send_run();
            end
            drain();
        end

        // a few cycles more to catch stray events
        repeat (20) @(posedge aclk);
        if (sb.errors == 0 && sb.expected_events.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/lcgp_pkg.sv
rtl/core/lcgp_datapath.sv
rtl/core/lcgp_ctrl.sv
rtl/core/lr_config_grammar_parser.sv
dv/lr_config_grammar_parser_test.sv
